// ===== sv/tsle_pkg.sv =====
// shared constants, action codes and the controller/datapath command and status types
// for the text screen line and character editor; no dependencies
`default_nettype none

package tsle_pkg;

   localparam int ROWS  = 32;
   localparam int COLS  = 132;
   localparam int CELLS = ROWS * COLS;
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = $clog2(CELLS);
   // column arithmetic: holds COLS itself and any 8-bit column field
   localparam int CW    = ($clog2(COLS + 1) > 8) ? $clog2(COLS + 1) : 8;
   // line arithmetic: holds ROWS itself and any 5-bit line field
   localparam int LW    = ((RW > 5) ? RW : 5) + 1;

   localparam logic [AW-1:0] COLS_A  = AW'(COLS);
   localparam logic [CW-1:0] COLS_C  = CW'(COLS);
   localparam logic [LW-1:0] ROWS_L  = LW'(ROWS);
   localparam logic [7:0]    BLANK_CHAR = 8'h20;
   localparam logic [7:0]    BLANK_ATTR = 8'h00;

   typedef logic [2:0] action_type;
   localparam action_type ACT_WRITE_CELL   = 3'd0;
   localparam action_type ACT_READ_CELL    = 3'd1;
   localparam action_type ACT_INSERT_CHARS = 3'd2;
   localparam action_type ACT_DELETE_CHARS = 3'd3;
   localparam action_type ACT_INSERT_LINES = 3'd4;
   localparam action_type ACT_DELETE_LINES = 3'd5;

   localparam logic REG_VT200_MODE = 1'b0;
   localparam logic REG_COLUMNS    = 1'b1;

   typedef struct packed {
      logic latch;
      logic decode;
      logic cell_op;
      logic rd_capture;
      logic shift;
      logic fill;
      logic map_copy;
      logic map_step;
      logic blank_row;
      logic blank_col;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cell_ok;
      logic char_ok;
      logic line_ok;
      logic is_read;
      logic line_full;
      logic shift_done;
      logic fill_last;
      logic map_last;
      logic col_last;
      logic row_last;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/tsle_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module tsle_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4224
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== sv/tsle_ctrl.sv =====
// controller state machine of the editor: sequences cell access, shifts, fills,
// row map rotation and row blanking; depends on tsle_pkg
`default_nettype none

module tsle_ctrl
   import tsle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output      logic    busy,
   output      cmd_type cmd
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_DECODE  = 11'b000_0000_0010,
      S_CELL    = 11'b000_0000_0100,
      S_RDWAIT  = 11'b000_0000_1000,
      S_SHIFT   = 11'b000_0001_0000,
      S_FILL    = 11'b000_0010_0000,
      S_MAPCOPY = 11'b000_0100_0000,
      S_MAPWR   = 11'b000_1000_0000,
      S_BLROW   = 11'b001_0000_0000,
      S_BLCOL   = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = start;
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.cell_ok)      state_in = S_CELL;
            else if (sts.char_ok) state_in = S_SHIFT;
            else if (sts.line_ok) state_in = sts.line_full ? S_BLROW : S_MAPCOPY;
            else                  state_in = S_DONE;
         end
         S_CELL: begin
            cmd.cell_op = 1'b1;
            state_in    = sts.is_read ? S_RDWAIT : S_DONE;
         end
         S_RDWAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_DONE;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) state_in = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) state_in = S_DONE;
         end
         S_MAPCOPY: begin
            cmd.map_copy = 1'b1;
            state_in     = S_MAPWR;
         end
         S_MAPWR: begin
            cmd.map_step = 1'b1;
            if (sts.map_last) state_in = S_BLROW;
         end
         S_BLROW: begin
            cmd.blank_row = 1'b1;
            state_in      = S_BLCOL;
         end
         S_BLCOL: begin
            cmd.blank_col = 1'b1;
            if (sts.col_last) state_in = sts.row_last ? S_DONE : S_BLROW;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/tsle_dp.sv =====
// datapath of the editor: item registers, row map, counters, cell ram and result
// registers; depends on tsle_pkg and tsle_ram
`default_nettype none

module tsle_dp
   import tsle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output      sts_type    sts,
   input  wire logic [2:0] req_action,
   input  wire logic [7:0] req_count,
   input  wire logic [4:0] req_line,
   input  wire logic [7:0] req_column,
   input  wire logic [4:0] req_scroll_bottom,
   input  wire logic       req_in_region,
   input  wire logic [7:0] req_cell_char,
   input  wire logic [7:0] req_cell_attr,
   input  wire logic       cfg_vt200_mode,
   input  wire logic [7:0] cfg_columns_in_use,
   output      logic       rsp_valid,
   output      logic [7:0] rsp_read_char,
   output      logic [7:0] rsp_read_attr,
   output      logic [4:0] rsp_redraw_first_line,
   output      logic [5:0] rsp_redraw_lines,
   output      logic [7:0] rsp_redraw_first_col,
   output      logic [7:0] rsp_redraw_cols,
   output      logic       rsp_cursor_moved,
   output      logic [4:0] rsp_new_cursor_line
);

   action_type      act_ff;
   logic [CW-1:0]   cnt_ff, col_ff, w_ff, m_ff, d_ff, f_ff, k_ff;
   logic [LW-1:0]   line_ff, bot_ff, i_ff, bl_ff;
   logic            region_ff, mode_ff;
   logic [7:0]      chr_ff, atr_ff;
   logic [AW-1:0]   base_ff, pend_addr_ff;
   logic            pend_ff;
   logic [15:0]     rd_ff;
   logic [RW-1:0]   rm_ff [ROWS];
   logic [RW-1:0]   sh_ff [ROWS];

   logic [CW-1:0]   w_in, cu, span_c, n_c, n_l_c, n_sel, src_c;
   logic [LW-1:0]   span_l, n_l, k_l, src_l;
   logic            ins, row_ok, bot_ok;
   logic [RW-1:0]   rm_idx, rm_rd;
   logic [AW-1:0]   base_in;
   logic            we;
   logic [AW-1:0]   waddr, raddr;
   logic [15:0]     wdata, rdata;

   // active width from the columns register, saturated to 1..COLS
   assign cu   = CW'(cfg_columns_in_use);
   assign w_in = (cu == '0) ? CW'(1) : ((cu > COLS_C) ? COLS_C : cu);

   assign ins    = (act_ff == ACT_INSERT_CHARS) || (act_ff == ACT_INSERT_LINES);
   assign row_ok = line_ff < ROWS_L;
   assign bot_ok = bot_ff < ROWS_L;

   // count clamps
   assign span_c = w_ff - col_ff;
   assign n_c    = (cnt_ff > span_c) ? span_c : cnt_ff;
   assign span_l = bot_ff - line_ff + LW'(1);
   assign n_l_c  = (cnt_ff > CW'(span_l)) ? CW'(span_l) : cnt_ff;
   assign n_l    = LW'(n_l_c);
   assign n_sel  = sts.char_ok ? n_c : n_l_c;

   always_comb begin
      sts            = '0;
      sts.cell_ok    = ((act_ff == ACT_WRITE_CELL) || (act_ff == ACT_READ_CELL))
                       && row_ok && (col_ff < COLS_C);
      sts.char_ok    = ((act_ff == ACT_INSERT_CHARS) || (act_ff == ACT_DELETE_CHARS))
                       && mode_ff && row_ok && (col_ff < w_ff);
      sts.line_ok    = ((act_ff == ACT_INSERT_LINES) || (act_ff == ACT_DELETE_LINES))
                       && mode_ff && region_ff && bot_ok && (line_ff <= bot_ff);
      sts.is_read    = (act_ff == ACT_READ_CELL);
      sts.line_full  = (n_l == span_l);
      sts.shift_done = (m_ff == '0);
      sts.fill_last  = (k_ff == CW'(1));
      sts.map_last   = (i_ff == bot_ff);
      sts.col_last   = (f_ff == w_ff - CW'(1));
      sts.row_last   = (k_ff == CW'(1));
   end

   // single row map read port
   assign rm_idx  = cmd.blank_row ? bl_ff[RW-1:0] : line_ff[RW-1:0];
   assign rm_rd   = rm_ff[rm_idx];
   assign base_in = AW'(rm_rd) * COLS_A;

   // rotation source for the screen line being rewritten
   assign k_l = i_ff - line_ff;
   always_comb begin
      if (ins) begin
         src_l = (k_l < cnt_ff[LW-1:0]) ? (bot_ff - k_l) : (i_ff - cnt_ff[LW-1:0]);
      end else begin
         src_l = (i_ff + cnt_ff[LW-1:0] <= bot_ff) ? (i_ff + cnt_ff[LW-1:0])
                                                   : (line_ff + bot_ff - i_ff);
      end
   end

   assign src_c = ins ? (d_ff - cnt_ff) : (d_ff + cnt_ff);

   always_comb begin
      we    = 1'b0;
      waddr = base_ff + AW'(f_ff);
      wdata = {BLANK_CHAR, BLANK_ATTR};
      if (pend_ff) begin
         we    = 1'b1;
         waddr = pend_addr_ff;
         wdata = rdata;
      end else if (cmd.fill || cmd.blank_col) begin
         we = 1'b1;
      end else if (cmd.cell_op && (act_ff == ACT_WRITE_CELL)) begin
         we    = 1'b1;
         waddr = base_ff + AW'(col_ff);
         wdata = {chr_ff, atr_ff};
      end
   end

   assign raddr = cmd.shift ? (base_ff + AW'(src_c)) : (base_ff + AW'(col_ff));

   tsle_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // payload and counters
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff    <= req_action;
         cnt_ff    <= (req_count == 8'd0) ? CW'(1) : CW'(req_count);
         line_ff   <= LW'(req_line);
         col_ff    <= CW'(req_column);
         bot_ff    <= LW'(req_scroll_bottom);
         region_ff <= req_in_region;
         chr_ff    <= req_cell_char;
         atr_ff    <= req_cell_attr;
         w_ff      <= w_in;
         mode_ff   <= cfg_vt200_mode;
      end
      if (cmd.decode) begin
         cnt_ff  <= n_sel;
         base_ff <= base_in;
         m_ff    <= span_c - n_c;
         d_ff    <= ins ? (w_ff - CW'(1)) : col_ff;
         f_ff    <= ins ? col_ff : (w_ff - n_c);
         k_ff    <= n_sel;
         i_ff    <= line_ff;
         bl_ff   <= ins ? line_ff : (bot_ff - n_l + LW'(1));
      end
      if (cmd.shift && (m_ff != '0)) begin
         pend_addr_ff <= base_ff + AW'(d_ff);
         d_ff         <= ins ? (d_ff - CW'(1)) : (d_ff + CW'(1));
         m_ff         <= m_ff - CW'(1);
      end
      if (cmd.fill) begin
         f_ff <= f_ff + CW'(1);
         k_ff <= k_ff - CW'(1);
      end
      if (cmd.map_copy) begin
         sh_ff <= rm_ff;
      end
      if (cmd.map_step) begin
         i_ff <= i_ff + LW'(1);
      end
      if (cmd.blank_row) begin
         base_ff <= base_in;
         f_ff    <= '0;
      end
      if (cmd.blank_col) begin
         f_ff <= f_ff + CW'(1);
         if (sts.col_last) begin
            bl_ff <= bl_ff + LW'(1);
            k_ff  <= k_ff - CW'(1);
         end
      end
      if (cmd.rd_capture) begin
         rd_ff <= rdata;
      end
      if (cmd.finish) begin
         rsp_read_char         <= '0;
         rsp_read_attr         <= '0;
         rsp_redraw_first_line <= '0;
         rsp_redraw_lines      <= '0;
         rsp_redraw_first_col  <= '0;
         rsp_redraw_cols       <= '0;
         rsp_cursor_moved      <= 1'b0;
         rsp_new_cursor_line   <= '0;
         if (sts.cell_ok && sts.is_read) begin
            rsp_read_char <= rd_ff[15:8];
            rsp_read_attr <= rd_ff[7:0];
         end
         if (sts.char_ok) begin
            rsp_redraw_first_line <= line_ff[4:0];
            rsp_redraw_lines      <= 6'd1;
            rsp_redraw_first_col  <= col_ff[7:0];
            rsp_redraw_cols       <= span_c[7:0];
         end
         if (sts.line_ok) begin
            rsp_redraw_first_line <= line_ff[4:0];
            rsp_redraw_lines      <= 6'(span_l);
            rsp_redraw_cols       <= w_ff[7:0];
            rsp_cursor_moved      <= 1'b1;
            rsp_new_cursor_line   <= line_ff[4:0];
         end
      end
   end

   // control state: row map, pending shift write, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            rm_ff[r] <= RW'(r);
         end
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (cmd.map_step) begin
            rm_ff[i_ff[RW-1:0]] <= sh_ff[src_l[RW-1:0]];
         end
         pend_ff   <= cmd.shift && (m_ff != '0);
         rsp_valid <= cmd.finish;
      end
   end

endmodule

`default_nettype wire

// ===== sv/text_screen_line_char_editor.sv =====
// top level of the text screen line and character editor: config registers,
// controller and datapath; depends on tsle_pkg, tsle_ctrl, tsle_dp
// cell write and cell read touch one cell; insert/delete chars shift and blank the cells
// of one row (one cell moved or blanked per cycle), line edits up to 32 rows of w cells
// plus the row map rotation; one item at a time, busy high throughout;
// the single-port-write cell ram sets the pace; result strobe is one cycle
// and cannot be stalled; synchronous reset restores the identity row map, vt200 on, 80 cols
`default_nettype none

module text_screen_line_char_editor
   import tsle_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_count,
   input  wire logic [4:0]  req_line,
   input  wire logic [7:0]  req_column,
   input  wire logic [4:0]  req_scroll_bottom,
   input  wire logic        req_in_region,
   input  wire logic [7:0]  req_cell_char,
   input  wire logic [7:0]  req_cell_attr,
   // result channel
   output      logic        rsp_valid,
   output      logic [7:0]  rsp_read_char,
   output      logic [7:0]  rsp_read_attr,
   output      logic [4:0]  rsp_redraw_first_line,
   output      logic [5:0]  rsp_redraw_lines,
   output      logic [7:0]  rsp_redraw_first_col,
   output      logic [7:0]  rsp_redraw_cols,
   output      logic        rsp_cursor_moved,
   output      logic [4:0]  rsp_new_cursor_line,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   logic    vt200_ff;
   logic [7:0] cols_ff;
   cmd_type cmd;
   sts_type sts;
   logic    wr_beat;

   // register writes complete on the access phase; word index is paddr[2]
   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         vt200_ff <= 1'b1;
         cols_ff  <= 8'd80;
      end else if (wr_beat) begin
         unique case (paddr[2])
            REG_VT200_MODE: vt200_ff <= pwdata[0];
            REG_COLUMNS:    cols_ff  <= pwdata[7:0];
            default:        ;
         endcase
      end
   end

   // read mux, low address bits ignored
   always_comb begin
      unique case (paddr[2])
         REG_VT200_MODE: prdata = {31'd0, vt200_ff};
         REG_COLUMNS:    prdata = {24'd0, cols_ff};
         default:        prdata = '0;
      endcase
   end

   // sequencer
   tsle_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // storage, counters and result registers
   tsle_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_action            (req_action),
      .req_count             (req_count),
      .req_line              (req_line),
      .req_column            (req_column),
      .req_scroll_bottom     (req_scroll_bottom),
      .req_in_region         (req_in_region),
      .req_cell_char         (req_cell_char),
      .req_cell_attr         (req_cell_attr),
      .cfg_vt200_mode        (vt200_ff),
      .cfg_columns_in_use    (cols_ff),
      .rsp_valid             (rsp_valid),
      .rsp_read_char         (rsp_read_char),
      .rsp_read_attr         (rsp_read_attr),
      .rsp_redraw_first_line (rsp_redraw_first_line),
      .rsp_redraw_lines      (rsp_redraw_lines),
      .rsp_redraw_first_col  (rsp_redraw_first_col),
      .rsp_redraw_cols       (rsp_redraw_cols),
      .rsp_cursor_moved      (rsp_cursor_moved),
      .rsp_new_cursor_line   (rsp_new_cursor_line)
   );

endmodule

`default_nettype wire

// ===== sv/tsle_chk.sv =====
// port-level checker for the editor and its bind to the top level
// depends on text_screen_line_char_editor
`default_nettype none

module tsle_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_read_char,
   input wire logic [7:0] rsp_read_attr,
   input wire logic [7:0] rsp_redraw_first_col,
   input wire logic       rsp_cursor_moved
);

   // an accepted beat keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // one result per item, never back to back
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the end of busy is always the result beat
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy ended without a result");

   // a line edit reads no cell and redraws from column 0
   a_line_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cursor_moved) |->
         (rsp_read_char == 8'd0 && rsp_read_attr == 8'd0 && rsp_redraw_first_col == 8'd0))
      else $error("line edit result carries cell or column data");

endmodule

bind text_screen_line_char_editor tsle_chk u_chk (.*);

`default_nettype wire
